// ----- rtl/integer_to_ascii_padded_unit_defines.svh -----
// Assertion macros for the integer to ASCII formatter.
`ifndef INTEGER_TO_ASCII_PADDED_UNIT_DEFINES_SVH
`define INTEGER_TO_ASCII_PADDED_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// clocked check, off while in reset
`define ITOA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// clocked check, also active in reset
`define ITOA_ASSERT_NR(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ITOA_ASSERT(lbl, prop, msg)
`define ITOA_ASSERT_NR(lbl, prop, msg)
`endif
`endif

// ----- rtl/itoa_pkg.sv -----
// Types, constants and character helpers for the integer to ASCII formatter.
package itoa_pkg;

	localparam int NDIG = 20;
	localparam int NDW  = $clog2(NDIG + 1);
	localparam int NUMW = 64;

	localparam logic [6:0] CH_SPACE = 7'h20;
	localparam logic [6:0] CH_MINUS = 7'h2D;
	localparam logic [6:0] CH_ZERO  = 7'h30;
	localparam logic [6:0] CH_UA    = 7'h41;
	localparam logic [6:0] CH_LA    = 7'h61;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_CLR,
		OP_BIT,
		OP_NIB
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     hex;
	} cell_ctl_t;

	typedef struct packed {
		logic [63:0] number;
		logic        is_signed;
		logic        hex_mode;
		logic        upper_case;
		logic [5:0]  field_width;
		logic        zero_fill;
		logic        flush_left;
	} cmd_t;

	typedef struct packed {
		logic [6:0] char_code;
		logic       last_char;
	} result_t;

	function automatic logic [6:0] digit_char(input logic [3:0] d, input logic upper);
		logic [6:0] base;
		base = upper ? CH_UA : CH_LA;
		if (d < 4'd10) begin
			digit_char = CH_ZERO + {3'b000, d};
		end else begin
			digit_char = base + {3'b000, d} - 7'd10;
		end
	endfunction

endpackage

// ----- rtl/itoa_cell.sv -----
// One digit cell: shift-and-correct bit step, nibble shift, clear.
module itoa_cell (
	input  logic               clk,
	input  itoa_pkg::cell_ctl_t ctl,
	input  logic               bit_in,
	input  logic [3:0]         nib_in,
	output logic               bit_out,
	output logic [3:0]         digit
);

	logic [3:0] digit_q;
	logic [3:0] corr;

	// add 3 when >= 5 in decimal so the shift carries correctly
	assign corr    = (!ctl.hex && digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	assign bit_out = corr[3];
	assign digit   = digit_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			itoa_pkg::OP_CLR:  digit_q <= 4'd0;
			itoa_pkg::OP_BIT:  digit_q <= {corr[2:0], bit_in};
			itoa_pkg::OP_NIB:  digit_q <= nib_in;
			default:           digit_q <= digit_q;
		endcase
	end

endmodule

// ----- rtl/integer_to_ascii_padded_unit.sv -----
// Top level of the integer to ASCII formatter: sequencer and digit cell row.
// An item is taken when start is high and busy is low. The magnitude is shifted
// bit by bit into a row of 20 digit cells, leading zero digits are then shifted
// out one a cycle, a planning state follows, and the field leaves one character
// a cycle with valid high, the final one flagged by last_char. Busy stays high
// until the final character is shown, so no new item is taken before then.
// Results cannot be held off, so each must be taken in the cycle it is shown.
`include "integer_to_ascii_padded_unit_defines.svh"

module integer_to_ascii_padded_unit #(
	parameter int MAX_WIDTH = 48
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  itoa_pkg::cmd_t    cmd,
	output logic              valid,
	output itoa_pkg::result_t result
);

	localparam int CW = $clog2(MAX_WIDTH + 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CONV,
		S_NORM,
		S_PLAN,
		S_LEAD,
		S_SIGN,
		S_ZERO,
		S_DIG,
		S_TRAIL
	} state_t;

	state_t                     state_q;
	logic [5:0]                 conv_q;
	logic [itoa_pkg::NUMW-1:0]  mag_q;
	logic                       neg_q;
	logic                       hex_q;
	logic                       upper_q;
	logic                       left_q;
	logic                       zp_q;
	logic [CW-1:0]              width_q;
	logic [itoa_pkg::NDW-1:0]   nd_q;
	logic [CW-1:0]              cnt_q;
	logic [CW-1:0]              rem_q;
	logic                       zero_q;
	logic                       trail_q;
	logic                       valid_q;
	itoa_pkg::result_t          result_q;

	itoa_pkg::cell_ctl_t        ctl;
	logic [3:0]                 digit [itoa_pkg::NDIG];
	logic                       bits  [itoa_pkg::NDIG];
	logic                       accept;
	logic                       norm_shift;
	logic [3:0]                 top;
	logic [CW-1:0]              body;
	logic [CW-1:0]              pad_c;
	logic                       lead_c;
	logic                       zero_c;
	logic                       trail_c;
	state_t                     nxt_sign;
	state_t                     nxt_lead;
	state_t                     nxt_plan;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign valid  = valid_q;
	assign result = result_q;
	assign top    = digit[itoa_pkg::NDIG-1];

	assign norm_shift = (state_q == S_NORM) && (top == 4'd0) && (nd_q > itoa_pkg::NDW'(1));

	always_comb begin
		ctl.hex = hex_q;
		if (accept) begin
			ctl.op = itoa_pkg::OP_CLR;
		end else if (state_q == S_CONV) begin
			ctl.op = itoa_pkg::OP_BIT;
		end else if (norm_shift || state_q == S_DIG) begin
			ctl.op = itoa_pkg::OP_NIB;
		end else begin
			ctl.op = itoa_pkg::OP_HOLD;
		end
	end

	for (genvar i = 0; i < itoa_pkg::NDIG; i++) begin : g_cell
		logic       b_in;
		logic [3:0] n_in;
		if (i == 0) begin : g_first
			assign b_in = mag_q[itoa_pkg::NUMW-1];
			assign n_in = 4'd0;
		end else begin : g_rest
			assign b_in = bits[i-1];
			assign n_in = digit[i-1];
		end
		itoa_cell u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.bit_in  (b_in),
			.nib_in  (n_in),
			.bit_out (bits[i]),
			.digit   (digit[i])
		);
	end

	// padding plan, used in the planning cycle
	always_comb begin
		body    = CW'(nd_q) + CW'(neg_q);
		pad_c   = (width_q > body) ? width_q - body : '0;
		lead_c  = (pad_c != '0) && !left_q && !zp_q;
		zero_c  = (pad_c != '0) && !left_q && zp_q;
		trail_c = (pad_c != '0) && left_q;
	end

	// fixed segment order: lead spaces, sign, zeros, digits, trailing spaces
	assign nxt_sign = zero_q ? S_ZERO : S_DIG;
	assign nxt_lead = neg_q ? S_SIGN : nxt_sign;
	assign nxt_plan = lead_c ? S_LEAD : (neg_q ? S_SIGN : (zero_c ? S_ZERO : S_DIG));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CONV;
					end
				end
				S_CONV: begin
					if (conv_q == 6'd63) begin
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					if (!norm_shift) begin
						state_q <= S_PLAN;
					end
				end
				S_PLAN: begin
					state_q <= nxt_plan;
				end
				S_LEAD: begin
					valid_q <= 1'b1;
					if (cnt_q == CW'(1)) begin
						state_q <= nxt_lead;
					end
				end
				S_SIGN: begin
					valid_q <= 1'b1;
					state_q <= nxt_sign;
				end
				S_ZERO: begin
					valid_q <= 1'b1;
					if (cnt_q == CW'(1)) begin
						state_q <= S_DIG;
					end
				end
				S_DIG: begin
					valid_q <= 1'b1;
					if (nd_q == itoa_pkg::NDW'(1)) begin
						state_q <= trail_q ? S_TRAIL : S_IDLE;
					end
				end
				S_TRAIL: begin
					valid_q <= 1'b1;
					if (cnt_q == CW'(1)) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					neg_q   <= !cmd.hex_mode && cmd.is_signed && cmd.number[63];
					mag_q   <= (!cmd.hex_mode && cmd.is_signed && cmd.number[63])
						? (64'd0 - cmd.number) : cmd.number;
					hex_q   <= cmd.hex_mode;
					upper_q <= cmd.upper_case;
					left_q  <= cmd.flush_left;
					zp_q    <= cmd.zero_fill;
					width_q <= (int'(cmd.field_width) > MAX_WIDTH)
						? CW'(MAX_WIDTH) : CW'(cmd.field_width);
					conv_q  <= 6'd0;
					nd_q    <= itoa_pkg::NDW'(itoa_pkg::NDIG);
				end
			end
			S_CONV: begin
				mag_q  <= {mag_q[itoa_pkg::NUMW-2:0], 1'b0};
				conv_q <= conv_q + 6'd1;
			end
			S_NORM: begin
				if (norm_shift) begin
					nd_q <= nd_q - itoa_pkg::NDW'(1);
				end
			end
			S_PLAN: begin
				cnt_q   <= pad_c;
				rem_q   <= body + pad_c;
				zero_q  <= zero_c;
				trail_q <= trail_c;
			end
			S_LEAD, S_ZERO, S_TRAIL: begin
				result_q.char_code <= (state_q == S_ZERO) ? itoa_pkg::CH_ZERO
					: itoa_pkg::CH_SPACE;
				result_q.last_char <= (rem_q == CW'(1));
				cnt_q <= cnt_q - CW'(1);
				rem_q <= rem_q - CW'(1);
			end
			S_SIGN: begin
				result_q.char_code <= itoa_pkg::CH_MINUS;
				result_q.last_char <= (rem_q == CW'(1));
				rem_q <= rem_q - CW'(1);
			end
			S_DIG: begin
				result_q.char_code <= itoa_pkg::digit_char(top, upper_q);
				result_q.last_char <= (rem_q == CW'(1));
				rem_q <= rem_q - CW'(1);
				nd_q  <= nd_q - itoa_pkg::NDW'(1);
			end
			default: begin
				mag_q <= mag_q;
			end
		endcase
	end

	`ITOA_ASSERT(a_more_chars_busy, (valid && !result.last_char) |-> busy, "non-final char with block idle")
	`ITOA_ASSERT(a_accept_quiet, (start && !busy) |=> !valid, "char emitted right after accept")
	`ITOA_ASSERT(a_conv_quiet, (state_q == S_CONV) |-> !valid_q, "char emitted during conversion")
	`ITOA_ASSERT(a_dig_count, (state_q == S_DIG) |-> (nd_q != '0), "digit state with no digits left")
	`ITOA_ASSERT_NR(a_char_nonzero, valid |-> (result.char_code != 7'd0), "NUL char emitted")

endmodule
